// File: rtl/cscalc_pkg.sv
// ----------------------------------------------------------------------------
// cscalc_pkg
// Shared widths, character codes, operator codes and the command and status
// structs between the calculator controller and its datapath.
// ----------------------------------------------------------------------------
package cscalc_pkg;

	// arithmetic width of operands and results
	localparam int DATA_WIDTH  = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int CHAR_WIDTH  = 8;
	localparam int CNT_WIDTH   = $clog2(DATA_WIDTH + 1);

	// ascii codes the automaton reacts to
	localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_WIDTH-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [CHAR_WIDTH-1:0] CHAR_EQUAL = 8'h3D;
	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CC_DIGIT,
		CC_PLUS,
		CC_MINUS,
		CC_STAR,
		CC_SLASH,
		CC_EQUAL,
		CC_OTHER
	} char_class_t;

	// controller to datapath
	typedef struct packed {
		logic acc_left;     // left = left * 10 + digit
		logic acc_right;    // right = right * 10 + digit
		logic flip_left;    // toggle left sign
		logic flip_right;   // toggle right sign
		logic fix_left;     // apply left sign, store operator from word
		logic prep_right;   // apply right sign, latch next operator from word
		logic div_start;    // launch the divider on left / right
		logic sel_div;      // commit takes the divider result
		logic commit_op;    // left = result, clear right
		logic commit_eq;    // load output register, clear operands
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pend_div;     // pending operator is divide
		logic div_done;     // divider result ready
		logic out_busy;     // output register holds an untaken word
	} dp_stat_t;

	function automatic char_class_t char_class(input logic [CHAR_WIDTH-1:0] c);
		char_class_t cls;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			cls = CC_DIGIT;
		end else if (c == CHAR_PLUS) begin
			cls = CC_PLUS;
		end else if (c == CHAR_MINUS) begin
			cls = CC_MINUS;
		end else if (c == CHAR_STAR) begin
			cls = CC_STAR;
		end else if (c == CHAR_SLASH) begin
			cls = CC_SLASH;
		end else if (c == CHAR_EQUAL) begin
			cls = CC_EQUAL;
		end else begin
			cls = CC_OTHER;
		end
		return cls;
	endfunction

	function automatic op_t op_of_char(input logic [CHAR_WIDTH-1:0] c);
		op_t op;
		case (c)
			CHAR_PLUS:  op = OP_ADD;
			CHAR_MINUS: op = OP_SUB;
			CHAR_STAR:  op = OP_MUL;
			default:    op = OP_DIV;
		endcase
		return op;
	endfunction

endpackage

// File: rtl/cscalc_div.sv
// ----------------------------------------------------------------------------
// cscalc_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. A zero divisor gives a zero quotient and raises the zero flag.
// ----------------------------------------------------------------------------
module cscalc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [cscalc_pkg::DATA_WIDTH-1:0]  dividend,
	input  logic [cscalc_pkg::DATA_WIDTH-1:0]  divisor,
	output logic                               done,
	output logic [cscalc_pkg::DATA_WIDTH-1:0]  quotient,
	output logic                               div_zero
);
	import cscalc_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIX
	} div_state_t;

	div_state_t             state_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [DATA_WIDTH-1:0]  rem_q;
	logic [DATA_WIDTH-1:0]  dq_q;      // dividend shifting out, quotient in
	logic [DATA_WIDTH-1:0]  dsr_q;
	logic                   neg_q;
	logic                   zero_q;
	logic                   done_q;
	logic [DATA_WIDTH-1:0]  quot_q;

	logic [DATA_WIDTH:0]    rem_sh;
	logic [DATA_WIDTH:0]    rem_sub;
	logic                   q_bit;
	logic [DATA_WIDTH-1:0]  mag_a;
	logic [DATA_WIDTH-1:0]  mag_b;

	// operand magnitudes
	assign mag_a = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

	// one restoring step
	assign rem_sh  = {rem_q, dq_q[DATA_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign q_bit   = ~rem_sub[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= '0;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_WIDTH'(DATA_WIDTH - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					state_q <= D_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the divider
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			rem_q  <= '0;
			dq_q   <= mag_a;
			dsr_q  <= mag_b;
			neg_q  <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
			zero_q <= (divisor == '0);
		end else if (state_q == D_RUN) begin
			rem_q <= q_bit ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
			dq_q  <= {dq_q[DATA_WIDTH-2:0], q_bit};
		end
		if (state_q == D_FIX) begin
			if (zero_q) begin
				quot_q <= '0;
			end else if (neg_q) begin
				quot_q <= ~dq_q + 1'b1;
			end else begin
				quot_q <= dq_q;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;
	assign div_zero = zero_q;

endmodule

// File: rtl/cscalc_dp.sv
// ----------------------------------------------------------------------------
// cscalc_dp
// Calculator datapath: operand and sign registers, operand accumulation,
// add/subtract/multiply unit, the divider and the output register.
// ----------------------------------------------------------------------------
module cscalc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [cscalc_pkg::CHAR_WIDTH-1:0]   char_code,
	input  cscalc_pkg::dp_cmd_t                 cmd,
	output cscalc_pkg::dp_stat_t                stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cscalc_pkg::VALUE_WIDTH-1:0] value,
	output logic                                div_error
);
	import cscalc_pkg::*;

	logic [DATA_WIDTH-1:0]         left_q;
	logic [DATA_WIDTH-1:0]         right_q;
	logic                          left_neg_q;
	logic                          right_neg_q;
	op_t                           op_q;
	op_t                           next_op_q;
	logic                          err_q;
	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	logic                          div_error_q;

	logic [DATA_WIDTH-1:0]         digit;
	logic [DATA_WIDTH-1:0]         left_acc;
	logic [DATA_WIDTH-1:0]         right_acc;
	logic [DATA_WIDTH-1:0]         alu_res;
	logic [DATA_WIDTH-1:0]         res;
	logic                          zero_now;
	logic                          div_done;
	logic [DATA_WIDTH-1:0]         div_quot;
	logic                          div_zero;

	// decimal accumulation: v * 10 + digit as two shifts and adds
	assign digit     = DATA_WIDTH'(char_code[3:0]);
	assign left_acc  = (left_q << 3) + (left_q << 1) + digit;
	assign right_acc = (right_q << 3) + (right_q << 1) + digit;

	// add, subtract, multiply on registered operands
	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = left_q + right_q;
			OP_SUB:  alu_res = left_q - right_q;
			OP_MUL:  alu_res = left_q * right_q;
			default: alu_res = '0;
		endcase
	end

	assign res      = cmd.sel_div ? div_quot : alu_res;
	assign zero_now = cmd.sel_div & div_zero;

	cscalc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (left_q),
		.divisor  (right_q),
		.done     (div_done),
		.quotient (div_quot),
		.div_zero (div_zero)
	);

	// operand state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			right_q     <= '0;
			left_neg_q  <= 1'b0;
			right_neg_q <= 1'b0;
			op_q        <= OP_ADD;
			next_op_q   <= OP_ADD;
			err_q       <= 1'b0;
		end else begin
			if (cmd.acc_left) begin
				left_q <= left_acc;
			end
			if (cmd.acc_right) begin
				right_q <= right_acc;
			end
			if (cmd.flip_left) begin
				left_neg_q <= ~left_neg_q;
			end
			if (cmd.flip_right) begin
				right_neg_q <= ~right_neg_q;
			end
			if (cmd.fix_left) begin
				if (left_neg_q) begin
					left_q <= ~left_q + 1'b1;
				end
				op_q <= op_of_char(char_code);
			end
			if (cmd.prep_right) begin
				if (right_neg_q) begin
					right_q <= ~right_q + 1'b1;
				end
				next_op_q <= op_of_char(char_code);
			end
			if (cmd.commit_op) begin
				left_q      <= res;
				right_q     <= '0;
				right_neg_q <= 1'b0;
				op_q        <= next_op_q;
				err_q       <= err_q | zero_now;
			end
			if (cmd.commit_eq) begin
				left_q      <= '0;
				right_q     <= '0;
				left_neg_q  <= 1'b0;
				right_neg_q <= 1'b0;
				err_q       <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit_eq) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_eq) begin
			value_q     <= VALUE_WIDTH'(signed'(res));
			div_error_q <= err_q | zero_now;
		end
	end

	assign stat.pend_div = (op_q == OP_DIV);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q & ~out_ready;

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign div_error = div_error_q;

endmodule

// File: rtl/cscalc_ctrl.sv
// ----------------------------------------------------------------------------
// cscalc_ctrl
// Calculator controller: the six-state character automaton and the phase
// sequencer that runs operator evaluation and result delivery.
// ----------------------------------------------------------------------------
module cscalc_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cscalc_pkg::CHAR_WIDTH-1:0]  char_code,
	input  cscalc_pkg::dp_stat_t               stat,
	output cscalc_pkg::dp_cmd_t                cmd
);
	import cscalc_pkg::*;

	typedef enum logic [2:0] {
		CS_START,    // expecting left operand
		CS_LSIGN,    // left sign seen
		CS_LDIGIT,   // inside left operand
		CS_RSTART,   // expecting right operand
		CS_RSIGN,    // right sign seen
		CS_RDIGIT    // inside right operand
	} calc_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_EXEC,
		PH_DIV,
		PH_COMMIT
	} phase_t;

	calc_state_t calc_q, calc_d;
	phase_t      phase_q, phase_d;
	logic        eq_q, eq_d;
	logic        sel_div_q, sel_div_d;

	char_class_t cls;
	logic        accept;
	logic        is_op;

	assign cls      = char_class(char_code);
	assign is_op    = (cls == CC_PLUS) || (cls == CC_MINUS) ||
	                  (cls == CC_STAR) || (cls == CC_SLASH);
	assign in_ready = (phase_q == PH_IDLE);
	assign accept   = in_valid & in_ready;

	// next state and datapath commands
	always_comb begin
		calc_d    = calc_q;
		phase_d   = phase_q;
		eq_d      = eq_q;
		sel_div_d = sel_div_q;
		cmd       = '0;
		cmd.sel_div = sel_div_q;
		case (phase_q)
			PH_IDLE: begin
				if (accept) begin
					case (calc_q)
						CS_START, CS_LSIGN: begin
							if (cls == CC_MINUS) begin
								cmd.flip_left = 1'b1;
								calc_d = (calc_q == CS_START) ? CS_LSIGN : CS_START;
							end else if (cls == CC_DIGIT) begin
								cmd.acc_left = 1'b1;
								calc_d       = CS_LDIGIT;
							end
						end
						CS_LDIGIT: begin
							if (cls == CC_DIGIT) begin
								cmd.acc_left = 1'b1;
							end else if (is_op) begin
								cmd.fix_left = 1'b1;
								calc_d       = CS_RSTART;
							end
						end
						CS_RSTART, CS_RSIGN: begin
							if (cls == CC_MINUS) begin
								cmd.flip_right = 1'b1;
								calc_d = (calc_q == CS_RSTART) ? CS_RSIGN : CS_RSTART;
							end else if (cls == CC_DIGIT) begin
								cmd.acc_right = 1'b1;
								calc_d        = CS_RDIGIT;
							end
						end
						CS_RDIGIT: begin
							if (cls == CC_DIGIT) begin
								cmd.acc_right = 1'b1;
							end else if (is_op) begin
								cmd.prep_right = 1'b1;
								eq_d           = 1'b0;
								phase_d        = PH_EXEC;
								calc_d         = CS_RSTART;
							end else if (cls == CC_EQUAL) begin
								cmd.prep_right = 1'b1;
								eq_d           = 1'b1;
								phase_d        = PH_EXEC;
								calc_d         = CS_START;
							end
						end
						default: begin
							calc_d = calc_q;
						end
					endcase
				end
			end
			// start the divider or go straight to commit
			PH_EXEC: begin
				if (stat.pend_div) begin
					cmd.div_start = 1'b1;
					phase_d       = PH_DIV;
				end else begin
					sel_div_d = 1'b0;
					phase_d   = PH_COMMIT;
				end
			end
			PH_DIV: begin
				if (stat.div_done) begin
					sel_div_d = 1'b1;
					phase_d   = PH_COMMIT;
				end
			end
			// write back, holding a result word until the output is free
			PH_COMMIT: begin
				if (eq_q) begin
					if (!stat.out_busy) begin
						cmd.commit_eq = 1'b1;
						phase_d       = PH_IDLE;
					end
				end else begin
					cmd.commit_op = 1'b1;
					phase_d       = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_q    <= CS_START;
			phase_q   <= PH_IDLE;
			eq_q      <= 1'b0;
			sel_div_q <= 1'b0;
		end else begin
			calc_q    <= calc_d;
			phase_q   <= phase_d;
			eq_q      <= eq_d;
			sel_div_q <= sel_div_d;
		end
	end

endmodule

// File: rtl/char_stream_calculator_fsm_core.sv
// ----------------------------------------------------------------------------
// char_stream_calculator_fsm_core
// Digits, signs, operators and '=' in, one result word out per '=' that ends
//   a right operand. A digit, sign or ignored word is taken directly in idle;
//   an operator or '=' ending a right operand runs EXEC then COMMIT for + - *,
//   or EXEC, DIV and COMMIT for divide on the one-bit-per-cycle divider. No
//   word is taken during these phases; the next word is taken while a result
//   waits. Reset clears operands, signs, error flag and output valid.
// ----------------------------------------------------------------------------
module char_stream_calculator_fsm_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [cscalc_pkg::CHAR_WIDTH-1:0]         char_code,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [cscalc_pkg::VALUE_WIDTH-1:0] value,
	output logic                                      div_error
);
	import cscalc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// automaton and sequencer
	cscalc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.stat      (stat),
		.cmd       (cmd)
	);

	// operands, arithmetic and output register
	cscalc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.div_error (div_error)
	);

endmodule
